### src/rc4_stream_cipher_assert.svh
// Assertion macros used by the RC4 cipher checker.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Clocked assertion that is switched off while reset is applied.
`define RC4_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define RC4_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/rc4_pkg.sv
// Types and constants shared by the RC4 stream cipher modules.
package rc4_pkg;

    localparam int KEY_BYTES_MAX = 16;
    localparam int KEY_LEN_W     = $clog2(KEY_BYTES_MAX + 1);
    localparam int KEY_IDX_W     = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int KEY_REG_W     = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int BYTE_W        = 8;
    localparam int SBOX_DEPTH    = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(KEY_BYTES_MAX);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RD_N,
        ST_KS_RD_J,
        ST_KS_WR_J,
        ST_KS_WR_N,
        ST_PR_RD_I,
        ST_PR_RD_J,
        ST_PR_SWAP,
        ST_PR_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_KS_RD_N,
        OP_KS_RD_J,
        OP_KS_WR_J,
        OP_KS_WR_N,
        OP_PR_RD_I,
        OP_PR_RD_J,
        OP_PR_SWAP,
        OP_PR_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic ks_last;
        logic out_busy;
    } dp_status_t;

endpackage

### src/rc4_ctrl.sv
// Sequencing state machine for key scheduling and keystream generation.
module rc4_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                first_of_message,
    output logic                in_stall,
    output rc4_pkg::dp_cmd_t    cmd,
    input  rc4_pkg::dp_status_t status
);
    import rc4_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = first_of_message ? ST_INIT : ST_PR_RD_I;
                end
            end
            ST_INIT:    state_next = ST_KS_RD_N;
            ST_KS_RD_N: state_next = ST_KS_RD_J;
            ST_KS_RD_J: state_next = ST_KS_WR_J;
            ST_KS_WR_J: state_next = ST_KS_WR_N;
            ST_KS_WR_N: state_next = status.ks_last ? ST_PR_RD_I : ST_KS_RD_N;
            ST_PR_RD_I: state_next = ST_PR_RD_J;
            ST_PR_RD_J: state_next = ST_PR_SWAP;
            ST_PR_SWAP: state_next = ST_PR_OUT;
            ST_PR_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NOP;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.op   = in_valid ? OP_LOAD : OP_NOP;
            end
            ST_INIT:    cmd.op = OP_INIT;
            ST_KS_RD_N: cmd.op = OP_KS_RD_N;
            ST_KS_RD_J: cmd.op = OP_KS_RD_J;
            ST_KS_WR_J: cmd.op = OP_KS_WR_J;
            ST_KS_WR_N: cmd.op = OP_KS_WR_N;
            ST_PR_RD_I: cmd.op = OP_PR_RD_I;
            ST_PR_RD_J: cmd.op = OP_PR_RD_J;
            ST_PR_SWAP: cmd.op = OP_PR_SWAP;
            ST_PR_OUT:  cmd.op = status.out_busy ? OP_NOP : OP_PR_OUT;
            default:    cmd.op = OP_NOP;
        endcase
    end

endmodule

### src/rc4_datapath.sv
// Permutation memory, index registers, key registers and output register.
module rc4_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rc4_pkg::dp_cmd_t                     cmd,
    output rc4_pkg::dp_status_t                  status,
    input  logic                                 cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rc4_pkg::KEY_REG_W-1:0]        cfg_data,
    input  logic [rc4_pkg::BYTE_W-1:0]           data_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rc4_pkg::BYTE_W-1:0]           result_byte
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0] sbox_mem [SBOX_DEPTH];
    logic [SBOX_DEPTH-1:0] vld_reg;
    logic [SBOX_DEPTH-1:0] vld_next;

    logic [BYTE_W-1:0] rd_reg;
    logic [BYTE_W-1:0] ra_reg;
    logic              rv_reg;
    logic [BYTE_W-1:0] rval;

    logic [BYTE_W-1:0] ra;
    logic [BYTE_W-1:0] wa;
    logic [BYTE_W-1:0] wd;
    logic              we;

    logic [BYTE_W-1:0]    i_reg, i_next;
    logic [BYTE_W-1:0]    j_reg, j_next;
    logic [BYTE_W-1:0]    n_reg, n_next;
    logic [KEY_IDX_W-1:0] k_reg, k_next;
    logic [BYTE_W-1:0]    a_reg, a_next;
    logic [BYTE_W-1:0]    b_reg, b_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic [BYTE_W-1:0]    out_data_reg, out_data_next;
    logic                 out_valid_reg, out_valid_next;

    logic [KEY_REG_W-1:0] key_low_reg;
    logic [KEY_REG_W-1:0] key_high_reg;
    logic [KEY_LEN_W-1:0] key_len_reg;

    logic [2*KEY_REG_W-1:0] key_all;
    logic [BYTE_W-1:0]      key_byte;
    logic [KEY_LEN_W-1:0]   eff_len;
    logic [BYTE_W-1:0]      keystream;

    assign rval     = rv_reg ? rd_reg : ra_reg;
    assign key_all  = {key_high_reg, key_low_reg};
    assign key_byte = key_all[{k_reg, 3'b000} +: BYTE_W];

    always_comb
    begin
        priority if (key_len_reg == '0)
        begin
            eff_len = KEY_LEN_W'(1);
        end
        else if (key_len_reg > KEY_LEN_W'(KEY_BYTES_MAX))
        begin
            eff_len = KEY_LEN_W'(KEY_BYTES_MAX);
        end
        else
        begin
            eff_len = key_len_reg;
        end
    end

    // Bypass the two swap writes when the keystream read hits a swapped entry.
    always_comb
    begin
        priority if (ra_reg == i_reg)
        begin
            keystream = b_reg;
        end
        else if (ra_reg == j_reg)
        begin
            keystream = a_reg;
        end
        else
        begin
            keystream = rval;
        end
    end

    always_comb
    begin
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        data_next      = data_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        vld_next       = vld_reg;
        ra             = ra_reg;
        wa             = n_reg;
        wd             = b_reg;
        we             = 1'b0;
        unique case (cmd.op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                data_next = data_byte;
            end
            OP_INIT:
            begin
                vld_next = '0;
                i_next   = '0;
                j_next   = '0;
                n_next   = '0;
                k_next   = '0;
            end
            OP_KS_RD_N:
            begin
                ra = n_reg;
            end
            OP_KS_RD_J:
            begin
                a_next = rval;
                j_next = j_reg + rval + key_byte;
                ra     = j_next;
            end
            OP_KS_WR_J:
            begin
                b_next = rval;
                we     = 1'b1;
                wa     = j_reg;
                wd     = a_reg;
            end
            OP_KS_WR_N:
            begin
                we     = 1'b1;
                wa     = n_reg;
                wd     = b_reg;
                n_next = n_reg + BYTE_W'(1);
                if (KEY_LEN_W'(k_reg) + KEY_LEN_W'(1) == eff_len)
                begin
                    k_next = '0;
                end
                else
                begin
                    k_next = k_reg + KEY_IDX_W'(1);
                end
                if (n_reg == BYTE_W'(SBOX_DEPTH - 1))
                begin
                    j_next = '0;
                end
            end
            OP_PR_RD_I:
            begin
                i_next = i_reg + BYTE_W'(1);
                ra     = i_next;
            end
            OP_PR_RD_J:
            begin
                a_next = rval;
                j_next = j_reg + rval;
                ra     = j_next;
            end
            OP_PR_SWAP:
            begin
                b_next = rval;
                we     = 1'b1;
                wa     = j_reg;
                wd     = a_reg;
                ra     = a_reg + rval;
            end
            OP_PR_OUT:
            begin
                we             = 1'b1;
                wa             = i_reg;
                wd             = b_reg;
                out_data_next  = data_reg ^ keystream;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (we)
        begin
            vld_next[wa] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            sbox_mem[wa] <= wd;
        end
        rd_reg <= sbox_mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            ra_reg        <= '0;
            rv_reg        <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            key_len_reg   <= KEY_LEN_RESET;
        end
        else
        begin
            vld_reg       <= vld_next;
            ra_reg        <= ra;
            rv_reg        <= vld_reg[ra];
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    CFG_KEY_LEN:  key_len_reg  <= cfg_data[KEY_LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        data_reg     <= data_next;
        out_data_reg <= out_data_next;
    end

    assign status.ks_last  = (n_reg == BYTE_W'(SBOX_DEPTH - 1));
    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign result_byte     = out_data_reg;

endmodule

### src/rc4_stream_cipher.sv
// A byte without the first flag passes the states read i, read j, swap and output; the next byte is
// taken only once the block is back in idle. A byte with the first flag first runs key scheduling:
// an init step, then read n, read j, write j and write n for each of the 256 permutation entries.
// The result register lets the next byte be accepted while a result waits to be taken.
// Reset is asynchronous: the permutation reads as identity at once through per-entry valid bits,
// both indices are zero, the key is zero and the key length is 16.
module rc4_stream_cipher (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rc4_pkg::BYTE_W-1:0]           data_byte,
    input  logic                                 first_of_message,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rc4_pkg::BYTE_W-1:0]           result_byte,
    input  logic                                 cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rc4_pkg::KEY_REG_W-1:0]        cfg_data
);
    import rc4_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rc4_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .first_of_message (first_of_message),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .status           (status)
    );

    rc4_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_byte (result_byte)
    );

endmodule

### src/rc4_checker.sv
// Port-level checker for the RC4 stream cipher and its bind statement.
module rc4_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       first_of_message,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] result_byte
);

`include "rc4_stream_cipher_assert.svh"

    // In the cycle after reset is seen the block is idle, ready for a beat and shows no result.
    `RC4_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "reset state not idle")

    // One byte is worked on at a time, so an accepted beat stalls the input next cycle.
    `RC4_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "input not stalled while busy")

    // A byte that continues the keystream has a result after read i, read j, swap and output.
    `RC4_ASSERT(a_stream_latency, in_valid && !in_stall && !first_of_message |=> ##4 out_valid, "result late")

    // A stalled result holds its value.
    `RC4_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(result_byte), "stalled result changed")

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);
